[rtl/lir_pkg.sv]
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Widths, constants, register indexes and shared types for the resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 5;
  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int ACC_W     = SAMPLE_W + 2;
  localparam int STEP_W    = 21;
  localparam int MAX_OUT   = 24;
  localparam int RUN_CNT_W = $clog2(MAX_OUT);
  localparam int BIT_CNT_W = $clog2(FRAC_BITS + 1);
  localparam int CFG_IDX_W = 2;

  // Position constants, one bit wider than the position to hold a sum.
  localparam logic [POS_W:0] ONE_X     = (POS_W + 1)'(1) << FRAC_BITS;
  localparam logic [POS_W:0] POS_MAX_X = {1'b0, {POS_W{1'b1}}};

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TWO_CH = CFG_IDX_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_MUL
  } lir_state_t;

  // Status of the serial multiplier.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

[rtl/linear_interp_resampler.sv]
// ----------------------------------------------------------------------------
// Linear interpolation sample rate converter
// Streaming resampler: one signed sample in, zero or more interpolated
// stereo or mono samples out.
// ----------------------------------------------------------------------------
// Usage
//   The in_ channel carries one signed 16-bit sample per transfer. For every
//   output position that falls inside the interval between the previous and
//   the current sample, one out_ transfer carries the interpolated value on
//   the left half of out_tdata and, in stereo mode, a copy on the right half
//   (zero in mono mode). out_tlast marks the final output caused by an input.
//   The very first sample after reset is only stored and produces nothing.
//   The cfg_ channel writes the step (index 0, input rate over output rate
//   with FRAC_BITS fraction bits) and the stereo flag (index 1); it is always
//   ready and must only be used while the block is idle.
// Timing
//   Each output's interpolation product is formed one multiplier bit per
//   cycle by the serial multiplier. An input yields at most MAX_OUT (24)
//   outputs, and no further input is taken until its last output is
//   loaded; an input that yields none leaves the block idle.
// Reset and stalls
//   Reset (synchronous, active low) clears the phase, the stored sample and
//   the pending output, and restores the register defaults. If the receiver
//   stalls, the finished output waits in the output register and the next
//   product waits in the multiplier; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input sample channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,   // [15:0] input_sample
  // Output sample channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // [15:0] left_sample,
                                                        // [31:16] right_sample
  output logic                              out_tlast,  // last_in_run
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lir_pkg::STEP_W-1:0]        cfg_data
);
  import lir_pkg::*;

  lir_state_t                 state_r, state_nxt;
  logic [STEP_W-1:0]          step_r;
  logic                       two_ch_r;
  logic                       have_prev_r;
  logic [SAMPLE_W-1:0]        prev_r;
  logic [SAMPLE_W-1:0]        cur_r;
  logic [POS_W-1:0]           pos_r;
  logic [RUN_CNT_W-1:0]       n_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_left_r;
  logic [SAMPLE_W-1:0]        out_right_r;
  logic                       out_last_r;

  logic                       in_acc;
  logic                       slot_free;
  logic                       out_load;
  logic                       pos_lt_one;
  logic [POS_W:0]             pos_sum;
  logic [POS_W:0]             pos_clamp;
  logic [POS_W:0]             pos_wrap;
  logic [POS_W-1:0]           pos_end;
  logic                       more;
  logic                       mul_start;
  logic [SAMPLE_W-1:0]        mul_cur;
  logic signed [DIFF_W-1:0]   mul_diff;
  logic [FRAC_BITS-1:0]       mul_frac;
  mul_stat_t                  mul_stat;
  logic signed [SAMPLE_W-1:0] mul_result;

  // Position arithmetic. The next position after an output is pos + step;
  // at the end of a run the interval is left by subtracting 1.0, dropping
  // any positions beyond the output cap and saturating at the largest value.
  always_comb begin
    pos_lt_one = ({1'b0, pos_r} < ONE_X);
    pos_sum    = {1'b0, pos_r} + (POS_W + 1)'(step_r);
    more       = (pos_sum < ONE_X) && (n_r != RUN_CNT_W'(MAX_OUT - 1));
    pos_clamp  = (pos_sum < ONE_X) ? ONE_X : pos_sum;
    pos_wrap   = pos_clamp - ONE_X;
    pos_end    = (pos_wrap > POS_MAX_X) ? POS_MAX_X[POS_W-1:0] : pos_wrap[POS_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && have_prev_r && pos_lt_one) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (out_load && !more) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    mul_start = 1'b0;
    mul_cur   = cur_r;
    mul_frac  = pos_sum[FRAC_BITS-1:0];
    slot_free = !out_valid_r || out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mul_cur   = in_tdata;
        mul_frac  = pos_r[FRAC_BITS-1:0];
        mul_start = in_tvalid && have_prev_r && pos_lt_one;
      end
      ST_MUL: begin
        out_load  = mul_stat.done && slot_free;
        mul_start = out_load && more;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign in_acc   = in_tvalid && in_tready;
  assign mul_diff = $signed({mul_cur[SAMPLE_W-1], mul_cur})
                  - $signed({prev_r[SAMPLE_W-1], prev_r});

  lir_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .diff   (mul_diff),
    .frac   (mul_frac),
    .prev   (prev_r),
    .stat   (mul_stat),
    .result (mul_result)
  );

  // Configuration registers; an unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      two_ch_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP:   step_r   <= cfg_data;
        REG_TWO_CH: two_ch_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Sequencer state, sample history and phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      prev_r      <= '0;
      pos_r       <= '0;
      n_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (!have_prev_r) begin
          // First sample: only remembered.
          prev_r      <= in_tdata;
          have_prev_r <= 1'b1;
        end else if (!pos_lt_one) begin
          // Position already past this interval: no output.
          prev_r <= in_tdata;
          pos_r  <= pos_r - ONE_X[POS_W-1:0];
        end else begin
          n_r <= '0;
        end
      end
      if (out_load) begin
        if (more) begin
          pos_r <= pos_sum[POS_W-1:0];
          n_r   <= n_r + RUN_CNT_W'(1);
        end else begin
          pos_r  <= pos_end;
          prev_r <= cur_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r <= in_tdata;
    end
  end

  // Output register: holds a finished sample while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= mul_result;
      out_right_r <= two_ch_r ? mul_result : '0;
      out_last_r  <= !more;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_right_r, out_left_r};
  assign out_tlast  = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n) (state_r == ST_IDLE) |-> !mul_stat.busy)
    else $error("multiplier running while sequencer is idle");
  assert property (@(posedge clk) disable iff (!rst_n) n_r < RUN_CNT_W'(MAX_OUT))
    else $error("output count beyond the cap");
  assert property (@(posedge clk) disable iff (!rst_n) (out_load && !more) |=> (state_r == ST_IDLE))
    else $error("run did not end after its last output");
  assert property (@(posedge clk) disable iff (!rst_n) (out_valid_r && !out_tready) |-> !out_load)
    else $error("pending output overwritten");

endmodule

[rtl/lir_mul.sv]
// ----------------------------------------------------------------------------
// Bit-serial interpolation multiplier
// Forms prev + diff * frac / 2^FRAC_BITS, truncated toward zero, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lir_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [lir_pkg::DIFF_W-1:0]   diff,
  input  logic        [lir_pkg::FRAC_BITS-1:0] frac,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] prev,
  output lir_pkg::mul_stat_t                  stat,
  output logic signed [lir_pkg::SAMPLE_W-1:0] result
);
  import lir_pkg::*;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [BIT_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]     hi_r, hi_nxt;
  logic [FRAC_BITS-1:0]        lo_r, lo_nxt;
  logic signed [ACC_W-1:0]     d_r;
  logic signed [SAMPLE_W-1:0]  prev_r;
  logic signed [ACC_W-1:0]     sum;
  logic signed [ACC_W-1:0]     whole;
  logic signed [ACC_W-1:0]     rounded;

  // One shift-add step: the low product bits replace the multiplier bits.
  always_comb begin
    sum      = hi_r + (lo_r[0] ? d_r : '0);
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      hi_nxt   = '0;
      lo_nxt   = frac;
    end else if (busy_r) begin
      hi_nxt  = sum >>> 1;
      lo_nxt  = {sum[0], lo_r[FRAC_BITS-1:1]};
      cnt_nxt = cnt_r + BIT_CNT_W'(1);
      if (cnt_r == BIT_CNT_W'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (start) begin
      d_r    <= {diff[DIFF_W-1], diff};
      prev_r <= prev;
    end
  end

  // The integer part of the full sum is prev + hi; a negative sum with a
  // non-zero fraction moves up by one to truncate toward zero.
  always_comb begin
    whole   = {{(ACC_W - SAMPLE_W){prev_r[SAMPLE_W-1]}}, prev_r} + hi_r;
    rounded = whole + ((whole[ACC_W-1] && (lo_r != '0)) ? ACC_W'(1) : '0);
  end

  assign result    = rounded[SAMPLE_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  assert property (@(posedge clk) disable iff (!rst_n) !(busy_r && done_r))
    else $error("multiplier busy and done together");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (busy_r && !start && cnt_r == BIT_CNT_W'(FRAC_BITS - 1)) |=> done_r)
    else $error("multiplier did not finish after its last bit");
  assert property (@(posedge clk) disable iff (!rst_n) start |=> (busy_r && cnt_r == '0))
    else $error("multiplier did not start");

endmodule

[verif/lir_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler scoreboard package
// Holds a cycle-free model of the interpolating resampler and a queue of the
// output samples it predicts, checked in order against the block's outputs.
// ----------------------------------------------------------------------------
package lir_tb_pkg;

  import lir_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
  } lir_frame_t;

  class resample_scoreboard;

    logic [STEP_W-1:0]          step;
    bit                         stereo;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic [POS_W-1:0]           position;
    bit                         have_prev;
    lir_frame_t                 expected_q[$];
    int unsigned                fail_count;
    int unsigned                results_seen;

    function new();
      step         = STEP_RESET;
      stereo       = 1'b1;
      prev_sample  = '0;
      position     = '0;
      have_prev    = 1'b0;
      fail_count   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
      case (idx)
        REG_STEP:   step   = data;
        REG_TWO_CH: stereo = data[0];
        default: ;
      endcase
    endfunction

    // prev + (cur - prev) * frac, with the whole sum truncated toward zero.
    function logic [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                        logic signed [SAMPLE_W-1:0] b,
                                        longint unsigned frac);
      longint num;
      longint q;
      num = longint'(a) * (longint'(1) << FRAC_BITS)
          + (longint'(b) - longint'(a)) * longint'(frac);
      if (num >= 0) q = num >>> FRAC_BITS;
      else q = -((-num) >>> FRAC_BITS);
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] raw);
      logic signed [SAMPLE_W-1:0] cur;
      longint unsigned            p;
      longint unsigned            one;
      longint unsigned            pos_max;
      int                         n;
      lir_frame_t                 f;
      cur     = raw;
      one     = longint'(1) << FRAC_BITS;
      pos_max = (longint'(1) << POS_W) - 1;
      if (!have_prev) begin
        prev_sample = cur;
        have_prev   = 1'b1;
        return;
      end
      p = position;
      n = 0;
      while (p < one && n < MAX_OUT) begin
        f.left  = blend(prev_sample, cur, p);
        f.right = stereo ? f.left : '0;
        f.last  = (p + step >= one) || (n == MAX_OUT - 1);
        expected_q.push_back(f);
        n++;
        p += step;
      end
      // When the output cap cuts the interval short the phase restarts at zero.
      if (p < one) p = one;
      p -= one;
      if (p > pos_max) p = pos_max;
      position    = p[POS_W-1:0];
      prev_sample = cur;
    endfunction

    function void check_result(logic [2*SAMPLE_W-1:0] data, logic last);
      lir_frame_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected output: left %h right %h last %b",
                   data[SAMPLE_W-1:0], data[2*SAMPLE_W-1:SAMPLE_W], last);
        return;
      end
      want = expected_q.pop_front();
      if (data[SAMPLE_W-1:0] !== want.left || data[2*SAMPLE_W-1:SAMPLE_W] !== want.right ||
          last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("output differs: expected left %h right %h last %b, got left %h right %h last %b",
                   want.left, want.right, want.last,
                   data[SAMPLE_W-1:0], data[2*SAMPLE_W-1:SAMPLE_W], last);
      end
    endfunction

  endclass

endpackage

[verif/tb_linear_interp_resampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler testbench
// Drives samples into the resampler under a range of step and channel
// settings, with random gaps on the input and random back-pressure on the
// output, and compares every output transfer with a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler;

  import lir_pkg::*;
  import lir_tb_pkg::*;

  // Indexes with no register behind them; writes to these must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(2731);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(1572864);
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(65536);

  // Cycles let pass once nothing is expected: an input that yields no output
  // does not keep the block busy, so this is ample.
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [15:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [STEP_W-1:0]    cfg_data;

  resample_scoreboard sb;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_req;
  // When set, the sender offers items back to back with no gaps.
  bit          steady;
  int unsigned cycles;

  linear_interp_resampler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hang anywhere in the run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("linear_interp_resampler: mismatch");
      $finish;
    end
  end

  // Every transfer is observed at the clock edge that completes it. All
  // stimulus is driven with nonblocking assignments, so the values seen here
  // are those that were present at the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Gap lengths: mostly short, now and then medium, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(30, 80);
  endfunction

  // Samples: full-scale extremes, small steps from the last sample so that
  // slopes are gentle, and otherwise uniform over the whole range.
  function automatic logic [15:0] pick_sample(logic [15:0] last_value);
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2:    v = last_value + 16'($urandom_range(0, 64)) - 16'd32;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    logic [STEP_W-1:0] s;
    case ($urandom_range(0, 4))
      0:       s = STEP_ONE;
      1:       s = STEP_W'($urandom_range(2731, 16384));
      2:       s = STEP_W'($urandom_range(16384, 131072));
      3:       s = STEP_W'($urandom_range(131072, 1572864));
      default: s = STEP_W'($urandom_range(2731, 1572864));
    endcase
    return s;
  endfunction

  // Offers one sample and returns at the edge where it is transferred.
  // tvalid stays high into the next item when there is no gap, so it is
  // never lowered and raised within one time step.
  task automatic send_sample(input logic [15:0] sample);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering input, waits for every predicted output and then lets the
  // block settle, so that a register write cannot land while it is at work.
  // The first edge lets the monitor note the last input transfer before the
  // queue of predictions is looked at.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the step and the channel mode, and optionally the two spare
  // indexes with random data. The stereo write carries random upper bits,
  // which the block must discard.
  task automatic program_regs(input logic [STEP_W-1:0] step, input bit stereo,
                              input bit spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [STEP_W-1:0]    val [4];
    int                   n;
    idx[0] = REG_STEP;
    val[0] = step;
    idx[1] = REG_TWO_CH;
    val[1] = {20'($urandom), stereo};
    idx[2] = REG_SPARE_2;
    val[2] = STEP_W'($urandom);
    idx[3] = REG_SPARE_3;
    val[3] = STEP_W'($urandom);
    n = spare ? 4 : 2;
    for (int i = 0; i < n; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver: bursts of readiness broken by stalls of random length, with
  // the occasional long stretch of steady readiness. On request it holds off
  // for a long time so that the block backs up and stops taking input.
  initial begin : receiver
    int run;
    int stall;
    int r;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      r   = $urandom_range(0, 99);
      run = (r < 10) ? 100 : $urandom_range(1, 8);
      r   = $urandom_range(0, 99);
      if (r < 60) stall = $urandom_range(0, 2);
      else if (r < 95) stall = $urandom_range(3, 8);
      else stall = $urandom_range(20, 60);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int                phase;
    int                n_items;
    int                random_items;
    logic [15:0]       last_value;
    logic [STEP_W-1:0] step;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    steady    = 1'b0;
    last_value = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, no writes yet: unit step in stereo. The first sample
    // is only stored; after that each output is the previous input, so the
    // full-scale swings come out exactly one sample late.
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);

    // Zero step: the position never advances, so every input hits the cap of
    // outputs and the phase restarts. The spare indexes are written as well.
    wait_idle();
    program_regs('0, 1'b1, 1'b1);
    send_sample(16'h7FFF);
    send_sample(16'h8000);

    // Smallest specified step, mono: exactly the full run of outputs, with
    // the right channel held at zero.
    wait_idle();
    program_regs(STEP_MIN, 1'b0, 1'b0);
    send_sample(16'h8000);
    send_sample(16'h7FFF);

    // A step below the specified range but above zero also runs into the cap
    // with part of the interval left over.
    wait_idle();
    program_regs(STEP_W'(1000), 1'b0, 1'b0);
    send_sample(16'h1234);
    send_sample(16'hEDCB);

    // Largest step: after one output the position lies far past the next
    // intervals, which then produce nothing and only pull it back.
    wait_idle();
    program_regs(STEP_MAX, 1'b1, 1'b0);
    repeat (4) begin
      last_value = pick_sample(last_value);
      send_sample(last_value);
    end

    // Random phases, each with its own setting. Runs at very large steps
    // give few outputs, so the phases go on until enough have been seen.
    random_items = 0;
    phase        = 0;
    while ((random_items < 100 || sb.results_seen < 48) && phase < 30) begin
      wait_idle();
      case (phase)
        0:       step = STEP_MIN;
        1:       step = STEP_MAX;
        2:       step = STEP_ONE;
        default: step = pick_step();
      endcase
      program_regs(step, bit'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      // The first phase runs without gaps while the receiver holds off, so
      // the block fills up and has to refuse input for a while.
      steady = (phase == 0) || ($urandom_range(0, 3) == 0);
      if (phase == 0) hold_req = 1'b1;
      n_items = $urandom_range(12, 25);
      repeat (n_items) begin
        last_value = pick_sample(last_value);
        send_sample(last_value);
      end
      random_items += n_items;
      phase++;
    end

    wait_idle();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("linear_interp_resampler: match");
    end else begin
      $display("linear_interp_resampler: mismatch");
    end
    $finish;
  end

endmodule
